>>> src/bfa_pkg.sv
package bfa_pkg;

    localparam int MAX_SEG = 64;
    localparam int SEG_IW  = $clog2(MAX_SEG);
    localparam int CNT_W   = SEG_IW + 1;
    localparam int GRAN    = 4096;
    localparam int GRAN_W  = $clog2(GRAN);
    localparam int ADDR_W  = 48;
    localparam int LEN_W   = 40;

    typedef struct packed {
        logic              action;
        logic [LEN_W-1:0]  request_size;
        logic [ADDR_W-1:0] free_address;
    } t_in_word;

    typedef struct packed {
        logic [ADDR_W-1:0] result_address;
        logic [2:0]        status;
        logic [LEN_W-1:0]  used_bytes;
        logic [LEN_W-1:0]  high_water;
    } t_out_word;

    typedef struct packed {
        logic             free;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] off;
    } t_seg;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_BAD_SIZE = 3'd1,
        STS_NO_MEM   = 3'd2,
        STS_BAD_FREE = 3'd3,
        STS_TBL_FULL = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        REG_BASE = 1'b0,
        REG_SIZE = 1'b1
    } t_reg;

    typedef enum logic [0:0] {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } t_action;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_INIT, CMD_ACCEPT, CMD_FAIL,
        CMD_A_RD, CMD_A_EV, CMD_A_PREP, CMD_SU_RD, CMD_SU_WR, CMD_W_HI, CMD_W_LO,
        CMD_F_RD, CMD_F_EV, CMD_F_NRD, CMD_F_NEV, CMD_F_WR, CMD_SD_RD, CMD_SD_WR,
        CMD_T_INIT, CMD_T_RD, CMD_T_EV, CMD_OUT_LOAD
    } t_cmd;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CHECK,
        S_A_RD, S_A_EV, S_A_DEC, S_SU_RD, S_SU_WR, S_W_HI, S_W_LO,
        S_F_RD, S_F_EV, S_F_NRD, S_F_NEV, S_F_WR, S_SD_TST, S_SD_RD, S_SD_WR,
        S_T_INIT, S_T_RD, S_T_EV, S_DONE
    } t_state;

    typedef struct packed {
        t_cmd    op;
        t_status code;
    } t_dp_cmd;

    typedef struct packed {
        logic free_op;
        logic bad_size;
        logic last;
        logic found;
        logic split;
        logic full;
        logic su_skip;
        logic su_last;
        logic f_match;
        logic more;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic        we;
        t_reg        idx;
        logic [63:0] data;
    } t_cfg_wr;

endpackage

>>> src/bfa_ctrl.sv
module bfa_ctrl import bfa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT:   n_state = S_IDLE;
            S_IDLE:   if (i_in_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (i_stat.free_op)       n_state = S_F_RD;
                else if (i_stat.bad_size) n_state = S_DONE;
                else                      n_state = S_A_RD;
            end
            S_A_RD:   n_state = S_A_EV;
            S_A_EV:   n_state = i_stat.last ? S_A_DEC : S_A_RD;
            S_A_DEC: begin
                if (!i_stat.found)                    n_state = S_DONE;
                else if (i_stat.split && i_stat.full) n_state = S_DONE;
                else if (!i_stat.split)               n_state = S_W_LO;
                else if (i_stat.su_skip)              n_state = S_W_HI;
                else                                  n_state = S_SU_RD;
            end
            S_SU_RD:  n_state = S_SU_WR;
            S_SU_WR:  n_state = i_stat.su_last ? S_W_HI : S_SU_RD;
            S_W_HI:   n_state = S_W_LO;
            S_W_LO:   n_state = S_T_INIT;
            S_F_RD:   n_state = S_F_EV;
            S_F_EV: begin
                if (i_stat.f_match)   n_state = i_stat.last ? S_F_WR : S_F_NRD;
                else if (i_stat.last) n_state = S_DONE;
                else                  n_state = S_F_RD;
            end
            S_F_NRD:  n_state = S_F_NEV;
            S_F_NEV:  n_state = S_F_WR;
            S_F_WR:   n_state = S_SD_TST;
            S_SD_TST: n_state = i_stat.more ? S_SD_RD : S_T_INIT;
            S_SD_RD:  n_state = S_SD_WR;
            S_SD_WR:  n_state = S_SD_TST;
            S_T_INIT: n_state = S_T_RD;
            S_T_RD:   n_state = S_T_EV;
            S_T_EV:   n_state = i_stat.last ? S_DONE : S_T_RD;
            S_DONE:   if (i_stat.out_free) n_state = S_IDLE;
            default:  n_state = S_INIT;
        endcase
    end

    always_comb begin
        o_cmd.op   = CMD_NONE;
        o_cmd.code = STS_OK;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_INIT:   o_cmd.op = CMD_INIT;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = CMD_ACCEPT;
            end
            S_CHECK: begin
                if (!i_stat.free_op && i_stat.bad_size) begin
                    o_cmd.op   = CMD_FAIL;
                    o_cmd.code = STS_BAD_SIZE;
                end
            end
            S_A_RD:   o_cmd.op = CMD_A_RD;
            S_A_EV:   o_cmd.op = CMD_A_EV;
            S_A_DEC: begin
                if (!i_stat.found) begin
                    o_cmd.op   = CMD_FAIL;
                    o_cmd.code = STS_NO_MEM;
                end else if (i_stat.split && i_stat.full) begin
                    o_cmd.op   = CMD_FAIL;
                    o_cmd.code = STS_TBL_FULL;
                end else begin
                    o_cmd.op = CMD_A_PREP;
                end
            end
            S_SU_RD:  o_cmd.op = CMD_SU_RD;
            S_SU_WR:  o_cmd.op = CMD_SU_WR;
            S_W_HI:   o_cmd.op = CMD_W_HI;
            S_W_LO:   o_cmd.op = CMD_W_LO;
            S_F_RD:   o_cmd.op = CMD_F_RD;
            S_F_EV: begin
                o_cmd.op = CMD_F_EV;
                if (!i_stat.f_match && i_stat.last) begin
                    o_cmd.op   = CMD_FAIL;
                    o_cmd.code = STS_BAD_FREE;
                end
            end
            S_F_NRD:  o_cmd.op = CMD_F_NRD;
            S_F_NEV:  o_cmd.op = CMD_F_NEV;
            S_F_WR:   o_cmd.op = CMD_F_WR;
            S_SD_TST: o_cmd.op = CMD_NONE;
            S_SD_RD:  o_cmd.op = CMD_SD_RD;
            S_SD_WR:  o_cmd.op = CMD_SD_WR;
            S_T_INIT: o_cmd.op = CMD_T_INIT;
            S_T_RD:   o_cmd.op = CMD_T_RD;
            S_T_EV:   o_cmd.op = CMD_T_EV;
            S_DONE:   if (i_stat.out_free) o_cmd.op = CMD_OUT_LOAD;
            default:  o_cmd.op = CMD_NONE;
        endcase
    end

endmodule

>>> src/bfa_datapath.sv
module bfa_datapath import bfa_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    output t_dp_stat          o_stat,
    input  t_cfg_wr           i_cfg,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    output logic [ADDR_W-1:0] o_base,
    output logic [LEN_W-1:0]  o_size
);

    t_seg mem [MAX_SEG];
    t_seg r_rd;
    logic              mem_we;
    logic [SEG_IW-1:0] mem_wa;
    t_seg              mem_wd;

    logic [ADDR_W-1:0] r_base;
    logic [LEN_W-1:0]  r_size;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_act;
    logic              r_zero;
    logic [LEN_W:0]    r_real;
    logic [ADDR_W-1:0] r_faddr;
    logic [CNT_W-1:0]  r_idx;
    logic              r_found;
    logic [SEG_IW-1:0] r_best;
    logic [LEN_W-1:0]  r_best_len;
    logic [LEN_W-1:0]  r_best_off;
    logic [ADDR_W-1:0] r_res_addr;
    t_status           r_status;
    logic [LEN_W-1:0]  r_used;
    logic [LEN_W-1:0]  r_hw;
    logic [LEN_W-1:0]  r_acc_used;
    logic [LEN_W-1:0]  r_acc_hw;
    logic [SEG_IW-1:0] r_k;
    logic              r_prev_free;
    logic [LEN_W-1:0]  r_prev_len;
    logic [LEN_W-1:0]  r_prev_off;
    logic [LEN_W-1:0]  r_mlen;
    logic [LEN_W-1:0]  r_moff;
    logic [1:0]        r_rm;
    logic              r_out_valid;
    t_out_word         r_out;

    logic [LEN_W:0]    n_real_sum;
    logic [LEN_W:0]    n_real;
    logic [SEG_IW-1:0] n_p;
    logic [LEN_W-1:0]  n_acc_used;
    logic [LEN_W-1:0]  n_acc_hw;
    logic [ADDR_W-1:0] rd_abs;
    logic              a_hit;

    // round up to the granule
    assign n_real_sum = {1'b0, i_in_word.request_size} + (LEN_W+1)'(GRAN - 1);
    assign n_real     = {n_real_sum[LEN_W:GRAN_W], {GRAN_W{1'b0}}};

    assign n_p    = r_k - SEG_IW'(r_prev_free);
    assign rd_abs = r_base + {{(ADDR_W-LEN_W){1'b0}}, r_rd.off};
    assign a_hit  = r_rd.free && (r_rd.len >= r_real[LEN_W-1:0])
                    && (!r_found || (r_rd.len < r_best_len));

    always_comb begin
        n_acc_used = r_acc_used;
        n_acc_hw   = r_acc_hw;
        if (!r_rd.free) begin
            n_acc_used = r_acc_used + r_rd.len;
            n_acc_hw   = r_rd.off + r_rd.len;
        end
    end

    always_comb begin
        o_stat.free_op  = (r_act == ACT_FREE);
        o_stat.bad_size = r_zero || (r_real >= {1'b0, r_size});
        o_stat.last     = (r_idx == r_cnt - CNT_W'(1));
        o_stat.found    = r_found;
        o_stat.split    = (r_best_len != r_real[LEN_W-1:0]);
        o_stat.full     = (r_cnt == CNT_W'(MAX_SEG));
        o_stat.su_skip  = ({1'b0, r_best} == r_cnt - CNT_W'(1));
        o_stat.su_last  = (r_idx[SEG_IW-1:0] == r_best + SEG_IW'(1));
        o_stat.f_match  = !r_rd.free && (rd_abs == r_faddr);
        o_stat.more     = (r_idx < r_cnt);
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

    // single write port of the segment table
    always_comb begin
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = r_rd;
        if (i_cfg.we) begin
            mem_we     = 1'b1;
            mem_wd.free = 1'b1;
            mem_wd.off  = '0;
            mem_wd.len  = (i_cfg.idx == REG_SIZE) ? i_cfg.data[LEN_W-1:0] : r_size;
        end else begin
            case (i_cmd.op)
                CMD_INIT: begin
                    mem_we = 1'b1;
                    mem_wd = '{free: 1'b1, len: r_size, off: '0};
                end
                CMD_SU_WR: begin
                    mem_we = 1'b1;
                    mem_wa = r_idx[SEG_IW-1:0] + SEG_IW'(1);
                end
                CMD_W_HI: begin
                    mem_we = 1'b1;
                    mem_wa = r_best + SEG_IW'(1);
                    mem_wd = '{free: 1'b1, len: r_best_len - r_real[LEN_W-1:0],
                               off: r_best_off + r_real[LEN_W-1:0]};
                end
                CMD_W_LO: begin
                    mem_we = 1'b1;
                    mem_wa = r_best;
                    mem_wd = '{free: 1'b0, len: r_real[LEN_W-1:0], off: r_best_off};
                end
                CMD_F_WR: begin
                    mem_we = 1'b1;
                    mem_wa = n_p;
                    mem_wd = '{free: 1'b1, len: r_mlen, off: r_moff};
                end
                CMD_SD_WR: begin
                    mem_we = 1'b1;
                    mem_wa = r_idx[SEG_IW-1:0] - SEG_IW'(r_rm);
                end
                default: mem_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[r_idx[SEG_IW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            CMD_ACCEPT: begin
                r_act       <= i_in_word.action;
                r_zero      <= (i_in_word.request_size == '0);
                r_real      <= n_real;
                r_faddr     <= i_in_word.free_address;
                r_res_addr  <= '0;
                r_status    <= STS_OK;
                r_prev_free <= 1'b0;
            end
            CMD_FAIL: r_status <= i_cmd.code;
            CMD_A_EV: begin
                if (a_hit) begin
                    r_best     <= r_idx[SEG_IW-1:0];
                    r_best_len <= r_rd.len;
                    r_best_off <= r_rd.off;
                end
            end
            CMD_A_PREP: r_res_addr <= r_base + {{(ADDR_W-LEN_W){1'b0}}, r_best_off};
            CMD_F_EV: begin
                if (o_stat.f_match) begin
                    r_k    <= r_idx[SEG_IW-1:0];
                    r_mlen <= r_rd.len + (r_prev_free ? r_prev_len : '0);
                    r_moff <= r_prev_free ? r_prev_off : r_rd.off;
                end else begin
                    r_prev_free <= r_rd.free;
                    r_prev_len  <= r_rd.len;
                    r_prev_off  <= r_rd.off;
                end
            end
            CMD_F_NEV: begin
                if (r_rd.free) begin
                    r_mlen <= r_mlen + r_rd.len;
                end
            end
            CMD_T_INIT: begin
                r_acc_used <= '0;
                r_acc_hw   <= '0;
            end
            CMD_T_EV: begin
                r_acc_used <= n_acc_used;
                r_acc_hw   <= n_acc_hw;
            end
            CMD_OUT_LOAD: begin
                r_out <= '{result_address: r_res_addr, status: r_status,
                           used_bytes: r_used, high_water: r_hw};
            end
            default: r_act <= r_act;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_size      <= LEN_W'(1048576);
            r_cnt       <= CNT_W'(1);
            r_idx       <= '0;
            r_found     <= 1'b0;
            r_rm        <= '0;
            r_used      <= '0;
            r_hw        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == CMD_OUT_LOAD) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_cmd.op)
                CMD_ACCEPT: begin
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_rm    <= '0;
                end
                CMD_A_EV: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (a_hit) r_found <= 1'b1;
                end
                CMD_A_PREP: r_idx <= r_cnt - CNT_W'(1);
                CMD_SU_WR:  r_idx <= r_idx - CNT_W'(1);
                CMD_W_HI:   r_cnt <= r_cnt + CNT_W'(1);
                CMD_F_EV: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (o_stat.f_match) r_rm <= {1'b0, r_prev_free};
                end
                CMD_F_NEV: if (r_rd.free) r_rm <= r_rm + 2'd1;
                CMD_F_WR:  r_idx <= {1'b0, n_p} + CNT_W'(1) + CNT_W'(r_rm);
                CMD_SD_WR: r_idx <= r_idx + CNT_W'(1);
                CMD_T_INIT: begin
                    r_idx <= '0;
                    r_cnt <= r_cnt - CNT_W'(r_rm);
                end
                CMD_T_EV: begin
                    r_idx <= r_idx + CNT_W'(1);
                    if (o_stat.last) begin
                        r_used <= n_acc_used;
                        r_hw   <= n_acc_hw;
                    end
                end
                default: r_idx <= r_idx;
            endcase
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    REG_BASE: r_base <= i_cfg.data[ADDR_W-1:0];
                    REG_SIZE: r_size <= i_cfg.data[LEN_W-1:0];
                    default:  r_base <= r_base;
                endcase
                r_cnt  <= CNT_W'(1);
                r_used <= '0;
                r_hw   <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    assign o_base      = r_base;
    assign o_size      = r_size;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt != '0) && (r_cnt <= CNT_W'(MAX_SEG)))
        else $error("segment count out of range");

    a_fail_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == CMD_OUT_LOAD && r_status != STS_OK) |-> (r_res_addr == '0))
        else $error("failed step carries an address");

    a_used_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= r_hw)
        else $error("bytes in use exceed high-water mark");

endmodule

>>> src/best_fit_block_allocator_core.sv
// best-fit segment allocator over one address region
// input word (i_in_valid / o_in_ready): action 0 allocates request_size bytes rounded up
// to a 4096-byte granule, action 1 releases the segment starting at free_address
// output word (o_out_valid / i_out_ready): start address, status, bytes in use and
// high-water mark after the step; exactly one output word per input word
// an input word is taken only when the engine is idle; one word is handled at a time
// allocate scans all n table entries, shifts the entries above a split best fit up,
// then a stats pass reads the table; free searches up to the match, merges free
// neighbours, shifts the entries behind down and runs the stats pass; one table write port
// a bad size fails right after the check; no fit, a full table and a bad free fail
// once the scan ends, skipping the table update and the stats pass
// a finished word waits in the output register; the engine takes the next input
// word meanwhile but holds its own result until the output register empties
// reset: one free segment of 1048576 bytes at base 0, seeded into the table by the init state
// apb writes to region_base (0x0) or region_size (0x8) reset the table to one free
// segment; write only while idle
module best_fit_block_allocator_core import bfa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_word   o_out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_dp_cmd           cmd;
    t_dp_stat          stat;
    t_cfg_wr           cfg;
    logic [ADDR_W-1:0] base;
    logic [LEN_W-1:0]  size;

    assign pready   = 1'b1;
    assign cfg.we   = psel && penable && pwrite;
    assign cfg.idx  = t_reg'(paddr[3]);
    assign cfg.data = pwdata;

    always_comb begin
        unique case (cfg.idx)
            REG_BASE: prdata = {{(64-ADDR_W){1'b0}}, base};
            REG_SIZE: prdata = {{(64-LEN_W){1'b0}}, size};
            default:  prdata = '0;
        endcase
    end

    bfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bfa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg       (cfg),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .o_base      (base),
        .o_size      (size)
    );

endmodule
